// ----- src/assert_macros.svh -----
// assertion macros shared by the decimal multiplier rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every rising clock edge, muted while reset is high
`define CHK_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked on every rising clock edge, reset included
`define CHK_PROP_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHK_PROP(label, clk, rst, prop, msg)
`define CHK_PROP_NORST(label, clk, prop, msg)
`endif

`endif

// ----- src/bcdm_pkg.sv -----
// types and constants of the decimal digit multiplier
`default_nettype none
package bcdm_pkg;

  localparam int LANE_DIGITS = 8;
  localparam int PROD_DIGITS = 2 * LANE_DIGITS;
  localparam int COLS = 2 * LANE_DIGITS - 1;
  localparam int COL_W = 10;
  localparam int HALF_DIGITS = PROD_DIGITS / 2;
  localparam int DEFAULT_OPERAND_DIGITS = 8;

  // column sums of the digit products
  typedef struct packed {
    logic invalid;
    logic [COLS-1:0][COL_W-1:0] col;
  } col_stage_t;

  // column sums split into hundreds and remainder
  typedef struct packed {
    logic invalid;
    logic [COLS-1:0][3:0] hund;
    logic [COLS-1:0][6:0] rem;
  } split_stage_t;

  // per-digit sums of units, tens and hundreds
  typedef struct packed {
    logic invalid;
    logic [PROD_DIGITS-1:0][4:0] dsum;
  } dsum_stage_t;

  // digit units and their small carries
  typedef struct packed {
    logic invalid;
    logic [PROD_DIGITS-1:0][3:0] unit;
    logic [PROD_DIGITS-1:0][1:0] cy;
  } unit_stage_t;

  // low half resolved, high half still raw
  typedef struct packed {
    logic invalid;
    logic [PROD_DIGITS-1:0][3:0] dig;
    logic c_mid;
  } part_stage_t;

endpackage
`default_nettype wire

// ----- src/bcdm_ifs.sv -----
// operand and product channel interfaces
`default_nettype none
interface bcdm_in_if;
  logic valid;
  logic ready;
  logic [31:0] multiplicand_bcd;
  logic [31:0] multiplier_bcd;
  modport source (output valid, multiplicand_bcd, multiplier_bcd, input ready);
  modport sink (input valid, multiplicand_bcd, multiplier_bcd, output ready);
endinterface

interface bcdm_out_if;
  logic valid;
  logic ready;
  logic [63:0] product_bcd;
  logic invalid_digit;
  modport source (output valid, product_bcd, invalid_digit, input ready);
  modport sink (input valid, product_bcd, invalid_digit, output ready);
endinterface
`default_nettype wire

// ----- src/bcdm_colsum.sv -----
// first stage: digit check and column sums of digit products
`default_nettype none
module bcdm_colsum #(
  parameter int OPERAND_DIGITS = bcdm_pkg::DEFAULT_OPERAND_DIGITS
) (
  input  wire logic clk,
  input  wire logic rst,
  bcdm_in_if.sink src,
  output logic out_valid,
  input  wire logic out_ready,
  output bcdm_pkg::col_stage_t out_data
);

  localparam int USED = (OPERAND_DIGITS > bcdm_pkg::LANE_DIGITS) ?
                        bcdm_pkg::LANE_DIGITS : OPERAND_DIGITS;

  logic [bcdm_pkg::LANE_DIGITS-1:0][3:0] a_dig;
  logic [bcdm_pkg::LANE_DIGITS-1:0][3:0] b_dig;
  logic bad;
  bcdm_pkg::col_stage_t data_next;

  // unpack used digits and flag any nibble above nine
  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < bcdm_pkg::LANE_DIGITS; i++) begin
      if (i < USED) begin
        a_dig[i] = src.multiplicand_bcd[4*i +: 4];
        b_dig[i] = src.multiplier_bcd[4*i +: 4];
        if (a_dig[i] > 4'd9 || b_dig[i] > 4'd9) bad = 1'b1;
      end else begin
        a_dig[i] = 4'd0;
        b_dig[i] = 4'd0;
      end
    end
  end

  // sum digit products by column, zero when invalid
  always_comb begin
    data_next.invalid = bad;
    data_next.col = '0;
    for (int i = 0; i < bcdm_pkg::LANE_DIGITS; i++) begin
      for (int j = 0; j < bcdm_pkg::LANE_DIGITS; j++) begin
        data_next.col[i+j] = data_next.col[i+j] +
          bcdm_pkg::COL_W'(a_dig[i]) * bcdm_pkg::COL_W'(b_dig[j]);
      end
    end
    if (bad) data_next.col = '0;
  end

  assign src.ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (src.ready) begin
      out_valid <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src.ready && src.valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/bcdm_digitize.sv -----
// two stages: column sums to decimal digits, then per-digit sums
`default_nettype none
module bcdm_digitize (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire bcdm_pkg::col_stage_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output bcdm_pkg::dsum_stage_t out_data
);

  logic s2_valid;
  logic s2_ready;
  bcdm_pkg::split_stage_t s2_data;
  bcdm_pkg::split_stage_t s2_next;
  bcdm_pkg::dsum_stage_t s3_next;
  logic [bcdm_pkg::COLS-1:0][3:0] tens;
  logic [bcdm_pkg::COLS-1:0][3:0] units;
  logic [15:0] hprod;
  logic [13:0] tprod;

  // hundreds by reciprocal multiply, remainder below one hundred
  always_comb begin
    s2_next.invalid = in_data.invalid;
    hprod = '0;
    for (int k = 0; k < bcdm_pkg::COLS; k++) begin
      hprod = 16'(in_data.col[k]) * 16'd41;
      s2_next.hund[k] = hprod[15:12];
      s2_next.rem[k] = 7'(in_data.col[k] -
                          bcdm_pkg::COL_W'(s2_next.hund[k]) * bcdm_pkg::COL_W'(100));
    end
  end

  // tens and units, then add the three shifted digit rows
  always_comb begin
    s3_next.invalid = s2_data.invalid;
    tprod = '0;
    for (int k = 0; k < bcdm_pkg::COLS; k++) begin
      tprod = 14'(s2_data.rem[k]) * 14'd103;
      tens[k] = tprod[13:10];
      units[k] = 4'(s2_data.rem[k] - 7'(tens[k]) * 7'd10);
    end
    for (int k = 0; k < bcdm_pkg::PROD_DIGITS; k++) begin
      s3_next.dsum[k] = 5'd0;
      if (k < bcdm_pkg::COLS) s3_next.dsum[k] = s3_next.dsum[k] + 5'(units[k]);
      if (k >= 1 && k - 1 < bcdm_pkg::COLS)
        s3_next.dsum[k] = s3_next.dsum[k] + 5'(tens[k-1]);
      if (k >= 2 && k - 2 < bcdm_pkg::COLS)
        s3_next.dsum[k] = s3_next.dsum[k] + 5'(s2_data.hund[k-2]);
    end
  end

  assign s2_ready = !out_valid || out_ready;
  assign in_ready = !s2_valid || s2_ready;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) s2_valid <= in_valid;
      if (s2_ready) out_valid <= s2_valid;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s2_data <= s2_next;
    if (s2_ready && s2_valid) out_data <= s3_next;
  end

endmodule
`default_nettype wire

// ----- src/bcdm_resolve.sv -----
// three stages: small carries, then decimal carry ripple in two halves
`default_nettype none
module bcdm_resolve (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire bcdm_pkg::dsum_stage_t in_data,
  bcdm_out_if.source dst
);

  logic s4_valid;
  logic s4_ready;
  bcdm_pkg::unit_stage_t s4_data;
  bcdm_pkg::unit_stage_t s4_next;
  logic s5_valid;
  logic s5_ready;
  bcdm_pkg::part_stage_t s5_data;
  bcdm_pkg::part_stage_t s5_next;
  logic [bcdm_pkg::PROD_DIGITS-1:0][3:0] prod_next;
  logic [4:0] v;
  logic cin;

  // split each digit sum into unit and carry of at most two
  always_comb begin
    s4_next.invalid = in_data.invalid;
    for (int k = 0; k < bcdm_pkg::PROD_DIGITS; k++) begin
      if (in_data.dsum[k] >= 5'd20) begin
        s4_next.cy[k] = 2'd2;
        s4_next.unit[k] = 4'(in_data.dsum[k] - 5'd20);
      end else if (in_data.dsum[k] >= 5'd10) begin
        s4_next.cy[k] = 2'd1;
        s4_next.unit[k] = 4'(in_data.dsum[k] - 5'd10);
      end else begin
        s4_next.cy[k] = 2'd0;
        s4_next.unit[k] = 4'(in_data.dsum[k]);
      end
    end
  end

  // add neighbor carries, ripple the low half
  always_comb begin
    s5_next.invalid = s4_data.invalid;
    cin = 1'b0;
    v = '0;
    for (int k = 0; k < bcdm_pkg::PROD_DIGITS; k++) begin
      s5_next.dig[k] = s4_data.unit[k];
      if (k > 0) s5_next.dig[k] = s4_data.unit[k] + 4'(s4_data.cy[k-1]);
    end
    for (int k = 0; k < bcdm_pkg::HALF_DIGITS; k++) begin
      v = 5'(s5_next.dig[k]) + 5'(cin);
      cin = (v >= 5'd10);
      s5_next.dig[k] = cin ? 4'(v - 5'd10) : 4'(v);
    end
    s5_next.c_mid = cin;
  end

  // ripple the high half
  logic [4:0] vh;
  logic ch;
  always_comb begin
    ch = s5_data.c_mid;
    vh = '0;
    prod_next = s5_data.dig;
    for (int k = bcdm_pkg::HALF_DIGITS; k < bcdm_pkg::PROD_DIGITS; k++) begin
      vh = 5'(s5_data.dig[k]) + 5'(ch);
      ch = (vh >= 5'd10);
      prod_next[k] = ch ? 4'(vh - 5'd10) : 4'(vh);
    end
  end

  assign s5_ready = !dst.valid || dst.ready;
  assign s4_ready = !s5_valid || s5_ready;
  assign in_ready = !s4_valid || s4_ready;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      dst.valid <= 1'b0;
    end else begin
      if (in_ready) s4_valid <= in_valid;
      if (s4_ready) s5_valid <= s4_valid;
      if (s5_ready) dst.valid <= s5_valid;
    end
  end

  // stage payloads, output register last
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s4_data <= s4_next;
    if (s4_ready && s4_valid) s5_data <= s5_next;
    if (s5_ready && s5_valid) begin
      dst.product_bcd <= prod_next;
      dst.invalid_digit <= s5_data.invalid;
    end
  end

endmodule
`default_nettype wire

// ----- src/decimal_digit_multiplier.sv -----
// BCD multiplier: operand beats in, sixteen-digit product beats out
// Channels: operand_in carries two eight-digit packed BCD operands, least
// significant digit in the low nibble; product_out returns the sixteen-digit
// BCD product and an invalid flag. A beat moves when valid and ready are high.
// Only the low OPERAND_DIGITS nibbles of each operand are used. A used nibble
// above nine raises invalid_digit and forces the product to zero.
// Throughput: one beat per cycle while product_out is not stalled; the six
// register stages are digit products and column sums, hundreds split,
// tens/units and row add, small carries, low-half carry ripple, and the
// high-half carry ripple into the output register.
// Each stage has its own valid bit; a stage takes a new beat whenever it is
// empty or its successor moves, so bubbles fill while the receiver stalls.
// When product_out is stalled the output register holds its beat, and
// operand_in stays ready until every stage is full.
// Reset (rst, synchronous) clears all valid bits; no beat is in flight after.
`default_nettype none
`include "assert_macros.svh"
module decimal_digit_multiplier #(
  parameter int OPERAND_DIGITS = bcdm_pkg::DEFAULT_OPERAND_DIGITS
) (
  input  wire logic clk,
  input  wire logic rst,
  bcdm_in_if.sink operand_in,
  bcdm_out_if.source product_out
);

  logic c_valid;
  logic c_ready;
  bcdm_pkg::col_stage_t c_data;
  logic d_valid;
  logic d_ready;
  bcdm_pkg::dsum_stage_t d_data;

  // digit products and column sums
  bcdm_colsum #(.OPERAND_DIGITS(OPERAND_DIGITS)) u_colsum (
    .clk(clk), .rst(rst), .src(operand_in),
    .out_valid(c_valid), .out_ready(c_ready), .out_data(c_data)
  );

  // columns to decimal digit sums
  bcdm_digitize u_digitize (
    .clk(clk), .rst(rst),
    .in_valid(c_valid), .in_ready(c_ready), .in_data(c_data),
    .out_valid(d_valid), .out_ready(d_ready), .out_data(d_data)
  );

  // carry resolution and output register
  bcdm_resolve u_resolve (
    .clk(clk), .rst(rst),
    .in_valid(d_valid), .in_ready(d_ready), .in_data(d_data),
    .dst(product_out)
  );

  // every product nibble is a decimal digit
  logic digits_ok;
  always_comb begin
    digits_ok = 1'b1;
    for (int k = 0; k < bcdm_pkg::PROD_DIGITS; k++) begin
      if (product_out.product_bcd[4*k +: 4] > 4'd9) digits_ok = 1'b0;
    end
  end

  `CHK_PROP(a_invalid_zero, clk, rst, product_out.valid && product_out.invalid_digit |-> product_out.product_bcd == '0, "invalid beat with nonzero product")
  `CHK_PROP(a_digits_bcd, clk, rst, product_out.valid |-> digits_ok, "product nibble above nine")
  `CHK_PROP_NORST(a_reset_empty, clk, rst |=> !product_out.valid, "output valid right after reset")

endmodule
`default_nettype wire

// ----- verif/tb_decimal_digit_multiplier.sv -----
// testbench of the decimal digit multiplier: directed table, then random operand beats
`timescale 1ns / 100ps
`default_nettype none
module tb_decimal_digit_multiplier;

  localparam int NDIG = bcdm_pkg::DEFAULT_OPERAND_DIGITS;
  localparam int RANDOM_BEATS = 1400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 20;
  localparam int NDIR = 16;

  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
  } operands_t;

  typedef struct {
    logic [63:0] product;
    logic        invalid;
  } product_t;

  // directed row: operands, and a typed-in answer where it is obvious
  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
    bit          typed;
    logic [63:0] product;
    logic        invalid;
  } dir_row_t;

  logic clk;
  logic rst;

  bcdm_in_if  operand_in ();
  bcdm_out_if product_out ();

  decimal_digit_multiplier dut (
    .clk(clk),
    .rst(rst),
    .operand_in(operand_in.sink),
    .product_out(product_out.source)
  );

  product_t pending_products[$];
  int errors = 0;
  int idle_cycles = 0;
  bit drive_done = 0;

  // decimal product of the low NDIG digits of each operand
  function automatic product_t bcd_product(logic [31:0] a, logic [31:0] b);
    product_t r;
    int col[2*16];
    int carry;
    int t;
    r.product = '0;
    r.invalid = 1'b0;
    for (int i = 0; i < 2*16; i++) col[i] = 0;
    for (int i = 0; i < NDIG; i++) begin
      if (a[4*i +: 4] > 9 || b[4*i +: 4] > 9) r.invalid = 1'b1;
    end
    if (r.invalid) return r;
    for (int i = 0; i < NDIG; i++)
      for (int j = 0; j < NDIG; j++)
        col[i+j] += a[4*i +: 4] * b[4*j +: 4];
    carry = 0;
    for (int i = 0; i < 2*16; i++) begin
      t = col[i] + carry;
      col[i] = t % 10;
      carry = t / 10;
    end
    for (int i = 0; i < 16; i++) r.product[4*i +: 4] = col[i][3:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_bcd();
    logic [31:0] v;
    for (int i = 0; i < 8; i++) v[4*i +: 4] = 4'($urandom_range(9, 0));
    return v;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // directed table
  dir_row_t dir_rows[NDIR];
  initial begin
    dir_rows[0]  = '{32'h0, 32'h0, 1, 64'h0, 1'b0};
    dir_rows[1]  = '{32'h99999999, 32'h99999999, 1, 64'h9999999800000001, 1'b0};
    dir_rows[2]  = '{32'h1, 32'h99999999, 1, 64'h99999999, 1'b0};
    dir_rows[3]  = '{32'h99999999, 32'h0, 1, 64'h0, 1'b0};
    dir_rows[4]  = '{32'hFFFFFFFF, 32'hFFFFFFFF, 1, 64'h0, 1'b1};
    dir_rows[5]  = '{32'h0000000A, 32'h1, 1, 64'h0, 1'b1};
    dir_rows[6]  = '{32'h1, 32'hA0000000, 1, 64'h0, 1'b1};
    dir_rows[7]  = '{32'hF0000000, 32'h0, 1, 64'h0, 1'b1};
    dir_rows[8]  = '{32'h12345678, 32'h87654321, 0, 64'h0, 1'b0};
    dir_rows[9]  = '{32'h10000000, 32'h10000000, 1, 64'h0100000000000000, 1'b0};
    dir_rows[10] = '{32'h00009999, 32'h00009999, 1, 64'h99980001, 1'b0};
    dir_rows[11] = '{32'h99990000, 32'h00009999, 0, 64'h0, 1'b0};
    dir_rows[12] = '{32'h55555555, 32'h2, 0, 64'h0, 1'b0};
    dir_rows[13] = '{32'h00000009, 32'h00000009, 1, 64'h81, 1'b0};
    dir_rows[14] = '{32'h9999999B, 32'h99999999, 1, 64'h0, 1'b1};
    dir_rows[15] = '{32'h50505050, 32'h05050505, 0, 64'h0, 1'b0};
  end

  task automatic send_beat(logic [31:0] a, logic [31:0] b, bit typed,
                           logic [63:0] prod, logic inv);
    product_t e;
    int g;
    g = gap_len();
    if (g > 0) begin
      operand_in.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    operand_in.valid <= 1'b1;
    operand_in.multiplicand_bcd <= a;
    operand_in.multiplier_bcd <= b;
    do @(posedge clk); while (!operand_in.ready);
    if (typed) begin
      e.product = prod;
      e.invalid = inv;
    end else begin
      e = bcd_product(a, b);
    end
    pending_products.insert(pending_products.size(), e);
  endtask

  // operand driver
  initial begin
    logic [31:0] a, b;
    int k;
    operand_in.valid <= 1'b0;
    operand_in.multiplicand_bcd <= '0;
    operand_in.multiplier_bcd <= '0;
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < NDIR; i++)
      send_beat(dir_rows[i].a, dir_rows[i].b, dir_rows[i].typed,
                dir_rows[i].product, dir_rows[i].invalid);
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      // hold off until the pipeline has drained, once along the way
      if (i == RANDOM_BEATS / 2) begin
        operand_in.valid <= 1'b0;
        while (pending_products.size() != 0) @(posedge clk);
      end
      k = $urandom_range(99, 0);
      a = rand_bcd();
      b = rand_bcd();
      if (k < 8) a = $urandom();
      else if (k < 16) b = $urandom();
      else if (k < 20) begin
        a[4*$urandom_range(7, 0) +: 4] = 4'($urandom_range(15, 10));
      end else if (k < 26) begin
        a = a >> (4 * $urandom_range(7, 0));
        b = b >> (4 * $urandom_range(7, 0));
      end
      send_beat(a, b, 0, '0, 1'b0);
    end
    operand_in.valid <= 1'b0;
    drive_done = 1'b1;
  end

  // receiver stalls
  initial begin
    int g;
    product_out.ready <= 1'b0;
    forever begin
      g = gap_len();
      if (g > 0) begin
        product_out.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      product_out.ready <= 1'b1;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
  end

  // product checker and watchdog
  always @(posedge clk) begin
    product_t e;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((operand_in.valid && operand_in.ready) ||
          (product_out.valid && product_out.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (product_out.valid && product_out.ready) begin
        if (pending_products.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected product beat %h inv %b",
                     product_out.product_bcd, product_out.invalid_digit);
        end else begin
          e = pending_products.pop_front();
          if (product_out.product_bcd !== e.product ||
              product_out.invalid_digit !== e.invalid) begin
            errors++;
            if (errors <= 10)
              $display("product exp %h inv %b, got %h inv %b", e.product, e.invalid,
                       product_out.product_bcd, product_out.invalid_digit);
          end
        end
      end
    end
  end

  // end of run
  initial begin
    wait (drive_done);
    while (pending_products.size() != 0 && idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("decimal_digit_multiplier: mismatch");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (errors == 0 && pending_products.size() == 0)
        $display("decimal_digit_multiplier: match");
      else
        $display("decimal_digit_multiplier: mismatch");
    end
    $finish;
  end

  // watchdog while stimulus is still going
  initial begin
    wait (!drive_done && idle_cycles >= WATCHDOG_LIMIT);
    $display("decimal_digit_multiplier: mismatch");
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
+incdir+src
src/bcdm_pkg.sv
src/bcdm_ifs.sv
src/bcdm_colsum.sv
src/bcdm_digitize.sv
src/bcdm_resolve.sv
src/decimal_digit_multiplier.sv
verif/tb_decimal_digit_multiplier.sv
